>>> rtl/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg: shared types and constants of the heat diffusion stencil step
// Grid size, field widths, register indexes and the control/status structs.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int SIDE      = 256;
  localparam int COL_W     = $clog2(SIDE);

  localparam int CELL_W    = 32;
  localparam int HEAT_W    = 18;
  localparam int REG_W     = 16;
  localparam int TEMP_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int IN_W      = 56;   // cell_value + heat_amount, padded to bytes
  localparam int OUT_W     = 48;   // new_value + temperature

  localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_GAIN = 2'd3;

  localparam logic [REG_W-1:0] DECAY_RST     = 16'd65470;
  localparam logic [REG_W-1:0] TEMP_LOW_RST  = 16'd600;
  localparam logic [REG_W-1:0] TEMP_HIGH_RST = 16'd3000;
  localparam logic [REG_W-1:0] TEMP_GAIN_RST = 16'd9600;

  typedef struct packed {
    logic [REG_W-1:0] decay_factor;
    logic [REG_W-1:0] temp_low;
    logic [REG_W-1:0] temp_high;
    logic [REG_W-1:0] temp_gain;
  } cfg_t;

  typedef struct packed {
    logic load;       // capture input request, step counters
    logic rd;         // read line buffers
    logic sum;        // neighbor sum, line buffer update
    logic mul;        // decay multiply and saturate
    logic tmp;        // temperature gain multiply
    logic out_load;   // fill output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;       // current request produces a result
    logic out_busy;   // output register full and not being taken
  } dp_stat_t;

endpackage

>>> rtl/heat_diffusion_stencil_step.sv
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step: streaming four-neighbor heat diffusion update
// Takes the previous grid in raster order and emits the updated cells one row
// behind, each with a clipped temperature index.
//
// Input stream s_axis: one request per grid cell (cell value and the heat
// source of the cell being emitted). Row 0 requests give no result; a request
// at row r, column c gives cell (r-1, c). m_axis_tlast marks the last emitted
// cell of a frame; the bottom border row is never emitted.
// Each request goes from acceptance to the output register through read, sum,
// decay multiply, gain multiply and clip, the steps of the single-request
// sequencer, with registered line buffer reads. Row 0 requests free the input
// after the sum step. No new request is taken until the sequencer is idle.
// The output register decouples the sides: a new request is taken while a
// result waits; if the receiver still stalls when the next result is ready,
// the sequencer holds it and stops accepting. Reset clears the raster counters,
// the sequencer and the output valid, and loads register defaults. Line
// buffers are not cleared; every used entry is written earlier in the same
// frame. Config writes: cfg_index 0 decay_factor, 1 temp_low, 2 temp_high,
// 3 temp_gain, only while the block is idle: user rule, unchecked by the block.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hds_pkg::IN_W-1:0]      s_axis_tdata,   // cell_value, heat_amount
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [hds_pkg::OUT_W-1:0]     m_axis_tdata,   // new_value, temperature
  output logic                          m_axis_tlast,   // frame_last
  input  logic                          cfg_we,
  input  logic [hds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hds_pkg::REG_W-1:0]     cfg_data
);
  import hds_pkg::*;

  cfg_t              cfg;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [CELL_W-1:0] new_value;
  logic [TEMP_W-1:0] temperature;

  hds_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hds_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .cell_value  (s_axis_tdata[CELL_W-1:0]),
    .heat_amount (s_axis_tdata[CELL_W+HEAT_W-1:CELL_W]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .new_value   (new_value),
    .temperature (temperature),
    .frame_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {temperature, new_value};

endmodule

>>> rtl/hds_regs.sv
// ----------------------------------------------------------------------------
// hds_regs: configuration registers
// Write-only register file for decay factor and temperature mapping.
// ----------------------------------------------------------------------------
module hds_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hds_pkg::REG_W-1:0]     cfg_data,
  output hds_pkg::cfg_t                 cfg
);
  import hds_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_factor <= DECAY_RST;
      cfg.temp_low     <= TEMP_LOW_RST;
      cfg.temp_high    <= TEMP_HIGH_RST;
      cfg.temp_gain    <= TEMP_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DECAY:     cfg.decay_factor <= cfg_data;
        REG_TEMP_LOW:  cfg.temp_low     <= cfg_data;
        REG_TEMP_HIGH: cfg.temp_high    <= cfg_data;
        REG_TEMP_GAIN: cfg.temp_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/hds_ctrl.sv
// ----------------------------------------------------------------------------
// hds_ctrl: sequencer of the stencil step
// One-hot state machine stepping one request through read, sum, multiply,
// temperature and output stages; row 0 requests end after sum.
// ----------------------------------------------------------------------------
module hds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hds_pkg::dp_stat_t   stat,
  output hds_pkg::ctrl_cmd_t  cmd
);
  import hds_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_SUM  = 6'b000100,
    S_MUL  = 6'b001000,
    S_TMP  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = stat.emit ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_TMP;
      end
      S_TMP: begin
        cmd.tmp    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

>>> rtl/hds_dp.sv
// ----------------------------------------------------------------------------
// hds_dp: datapath of the stencil step
// Raster counters, two line buffers, neighbor average, decay multiply with
// saturation, temperature mapping and the output register.
// ----------------------------------------------------------------------------
module hds_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  hds_pkg::cfg_t               cfg,
  input  hds_pkg::ctrl_cmd_t          cmd,
  output hds_pkg::dp_stat_t           stat,
  input  logic [hds_pkg::CELL_W-1:0]  cell_value,
  input  logic [hds_pkg::HEAT_W-1:0]  heat_amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hds_pkg::CELL_W-1:0]  new_value,
  output logic [hds_pkg::TEMP_W-1:0]  temperature,
  output logic                        frame_last
);
  import hds_pkg::*;

  localparam logic [COL_W-1:0] LAST_IDX = COL_W'(SIDE - 1);
  localparam logic [COL_W-1:0] ONE      = COL_W'(1);

  logic [CELL_W-1:0] row_above     [SIDE];
  logic [CELL_W-1:0] row_two_above [SIDE];

  logic [COL_W-1:0]  row_count, col_count;
  logic [COL_W-1:0]  r_q, c_q;
  logic [CELL_W-1:0] cell_q;
  logic [HEAT_W-1:0] heat_q;

  logic [CELL_W-1:0] up_left, up_mid, ab_right, ab_mid;
  logic [CELL_W:0]   avg_heat;
  logic [CELL_W-1:0] nv;
  logic [23:0]       t_scaled;

  logic [CELL_W+1:0]        sum4;
  logic [CELL_W+REG_W:0]    dprod;
  logic [CELL_W+REG_W-1:0]  tprod;
  logic [24:0]              t_off;
  logic [CELL_W-1:0]        nv_sat;
  logic                     interior, is_last;

  assign stat.emit     = (r_q != '0);
  assign stat.out_busy = out_valid && !out_ready;

  assign interior = (r_q >= COL_W'(2)) && (c_q != '0) && (c_q != LAST_IDX);
  assign is_last  = (r_q == LAST_IDX) && (c_q == LAST_IDX);

  // raster position of the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (cmd.load) begin
      if (col_count == LAST_IDX) begin
        col_count <= '0;
        row_count <= (row_count == LAST_IDX) ? '0 : row_count + ONE;
      end else begin
        col_count <= col_count + ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cell_q <= cell_value;
      heat_q <= heat_amount;
      r_q    <= row_count;
      c_q    <= col_count;
    end
  end

  // line buffer reads: left and up from the lower buffer, right from the upper
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      up_left  <= row_two_above[c_q - ONE];
      up_mid   <= row_two_above[c_q];
      ab_right <= row_above[c_q + ONE];
      ab_mid   <= row_above[c_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      row_two_above[c_q] <= ab_mid;
      row_above[c_q]     <= cell_q;
    end
  end

  assign sum4 = (CELL_W+2)'(up_left) + (CELL_W+2)'(up_mid)
              + (CELL_W+2)'(ab_right) + (CELL_W+2)'(cell_q);

  always_ff @(posedge clk) begin
    if (cmd.sum) avg_heat <= {1'b0, sum4[CELL_W+1:2]} + (CELL_W+1)'(heat_q);
  end

  assign dprod  = (CELL_W+REG_W+1)'(avg_heat) * (CELL_W+REG_W+1)'(cfg.decay_factor);
  assign nv_sat = (dprod[CELL_W+REG_W] != 1'b0) ? '1 : dprod[CELL_W+REG_W-1:REG_W];

  always_ff @(posedge clk) begin
    if (cmd.mul) nv <= interior ? nv_sat : '0;
  end

  assign tprod = (CELL_W+REG_W)'(nv) * (CELL_W+REG_W)'(cfg.temp_gain);

  always_ff @(posedge clk) begin
    if (cmd.tmp) t_scaled <= tprod[CELL_W+REG_W-1:24];
  end

  assign t_off = 25'(t_scaled) + 25'(cfg.temp_low);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      new_value   <= nv;
      temperature <= (t_off > 25'(cfg.temp_high)) ? cfg.temp_high : t_off[TEMP_W-1:0];
      frame_last  <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready)    out_valid <= 1'b0;
  end

endmodule

>>> tb/sv/heat_diffusion_stencil_step_chk.sv
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step_chk: scoreboard for the diffusion stencil step
// Watches the request, result and register ports, keeps its own line buffers,
// raster position and register copies, predicts each updated cell and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_step_chk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [hds_pkg::IN_W-1:0]      s_axis_tdata,   // cell_value, heat_amount
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [hds_pkg::OUT_W-1:0]     m_axis_tdata,   // new_value, temperature
  input  logic                          m_axis_tlast,   // frame_last
  input  logic                          cfg_we,
  input  logic [hds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hds_pkg::REG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            outstanding,
  output int                            checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import hds_pkg::*;

  typedef struct packed {
    logic [CELL_W-1:0] new_value;
    logic [TEMP_W-1:0] temperature;
    logic              frame_last;
  } cell_update_t;

  logic [REG_W-1:0]  decay_q, tlow_q, thigh_q, tgain_q;
  logic [CELL_W-1:0] line_up  [SIDE];
  logic [CELL_W-1:0] line_up2 [SIDE];
  int                row_pos, col_pos;
  cell_update_t      upd_q [$];
  int                errs, nchecked;

  function automatic logic [TEMP_W-1:0] temp_of(input logic [CELL_W-1:0] v);
    logic [63:0] t;
    t = ((64'(v) * 64'(tgain_q)) >> 24) + 64'(tlow_q);
    if (t > 64'(thigh_q))
      t = 64'(thigh_q);
    return t[TEMP_W-1:0];
  endfunction

  // one request: predict the cell one row up, then shift the line buffers
  function automatic void advance_grid(input logic [CELL_W-1:0] cell_in,
                                       input logic [HEAT_W-1:0] heat);
    logic [33:0]  nsum;
    logic [63:0]  scaled;
    cell_update_t u;
    if (row_pos >= 1) begin
      u.new_value = '0;
      if (row_pos >= 2 && col_pos >= 1 && col_pos < SIDE - 1) begin
        // left of row r-1 already moved to the lower buffer, center still row r-2
        nsum = 34'(line_up2[col_pos-1]) + 34'(line_up2[col_pos])
             + 34'(line_up[col_pos+1]) + 34'(cell_in);
        scaled = ((64'(nsum >> 2) + 64'(heat)) * 64'(decay_q)) >> 16;
        u.new_value = (scaled > 64'hFFFF_FFFF) ? '1 : scaled[CELL_W-1:0];
      end
      u.temperature = temp_of(u.new_value);
      u.frame_last  = (row_pos == SIDE - 1) && (col_pos == SIDE - 1);
      upd_q.push_back(u);
    end
    line_up2[col_pos] = line_up[col_pos];
    line_up[col_pos]  = cell_in;
    col_pos++;
    if (col_pos == SIDE) begin
      col_pos = 0;
      row_pos = (row_pos == SIDE - 1) ? 0 : row_pos + 1;
    end
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    errs++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
  endfunction

  always @(posedge clk) begin
    cell_update_t want;
    if (rst) begin
      decay_q  = DECAY_RST;
      tlow_q   = TEMP_LOW_RST;
      thigh_q  = TEMP_HIGH_RST;
      tgain_q  = TEMP_GAIN_RST;
      row_pos  = 0;
      col_pos  = 0;
      upd_q.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DECAY:     decay_q = cfg_data;
          REG_TEMP_LOW:  tlow_q  = cfg_data;
          REG_TEMP_HIGH: thigh_q = cfg_data;
          REG_TEMP_GAIN: tgain_q = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        advance_grid(s_axis_tdata[CELL_W-1:0], s_axis_tdata[CELL_W +: HEAT_W]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (upd_q.size() == 0) begin
          note_mismatch("unexpected result new_value", '0, m_axis_tdata[CELL_W-1:0]);
        end else begin
          want = upd_q.pop_front();
          nchecked++;
          if (m_axis_tdata[CELL_W-1:0] !== want.new_value)
            note_mismatch("new_value", want.new_value, m_axis_tdata[CELL_W-1:0]);
          if (m_axis_tdata[CELL_W +: TEMP_W] !== want.temperature)
            note_mismatch("temperature", 32'(want.temperature),
                          32'(m_axis_tdata[CELL_W +: TEMP_W]));
          if (m_axis_tlast !== want.frame_last)
            note_mismatch("frame_last", 32'(want.frame_last), 32'(m_axis_tlast));
        end
      end
    end
    fail_count  <= errs;
    outstanding <= upd_q.size();
    checked     <= nchecked;
  end

endmodule

>>> tb/sv/heat_diffusion_stencil_step_tb.sv
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step_tb: stimulus and verdict for the stencil step
// Streams grid cells through several register settings and idle patterns,
// starting with extreme cells and heat at the first interior row, then the rest
// of that row at random, then short runs of cells under varied register settings.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hds_pkg::*;

  typedef enum int {ROW_HOT, ROW_COLD, ROW_SMALL, ROW_WILD, ROW_MIXED} row_style_e;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;   // cell_value, heat_amount
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;         // new_value, temperature
  logic                 m_axis_tlast;         // frame_last
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_DECAY;
  logic [REG_W-1:0]     cfg_data      = '0;

  int         fail_count, outstanding, checked;
  int         send_idle_pct = 20;
  int         recv_idle_pct = 63;
  int         sent          = 0;
  int         settings_used = 1;
  row_style_e style         = ROW_WILD;

  heat_diffusion_stencil_step uut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  heat_diffusion_stencil_step_chk chk (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .outstanding, .checked
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #2_000_000;
    $display("timeout at %0t ns, %0d updates still outstanding", $realtime, outstanding);
    $display("heat_diffusion_stencil_step verification failed");
    $finish;
  end

  function automatic logic [CELL_W-1:0] pick_cell(input row_style_e s);
    unique case (s)
      ROW_HOT:   return ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(255)
                                                 : 32'hFFFF_FFFF;
      ROW_COLD:  return ($urandom_range(7) == 0) ? 32'($urandom_range(15)) : '0;
      ROW_SMALL: return 32'($urandom_range(32'h0003_FFFF));
      ROW_WILD:  return $urandom();
      default: begin
        unique case ($urandom_range(3))
          0:       return '0;
          1:       return '1;
          2:       return 32'h8000_0000 | 32'($urandom_range(255));
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic logic [HEAT_W-1:0] pick_heat();
    unique case ($urandom_range(3))
      0:       return '0;
      1:       return 18'd131072;
      default: return 18'($urandom_range(131072));
    endcase
  endfunction

  task automatic send_cell(input logic [CELL_W-1:0] cell_in,
                           input logic [HEAT_W-1:0] heat);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - HEAT_W - CELL_W){1'b0}}, heat, cell_in};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // each grid row gets one content style so neighbor sums reach the extremes
  task automatic stream_cells(input int n);
    for (int i = 0; i < n; i++) begin
      if (sent % SIDE == 0)
        style = row_style_e'($urandom_range(4));
      send_cell(pick_cell(style), pick_heat());
    end
  endtask

  // stop requesting, let every result out, then cover the no-result latency
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic program_regs(input logic [REG_W-1:0] decay, input logic [REG_W-1:0] lo,
                              input logic [REG_W-1:0] hi, input logic [REG_W-1:0] gain);
    logic [REG_W-1:0]     vals [4];
    logic [CFG_IDX_W-1:0] idx  [4];
    vals = '{decay, lo, hi, gain};
    idx  = '{REG_DECAY, REG_TEMP_LOW, REG_TEMP_HIGH, REG_TEMP_GAIN};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values; two saturated rows so row 2 sees hot neighbors
    for (int i = 0; i < 2 * SIDE; i++)
      send_cell('1, pick_heat());
    send_cell('1, 18'd131072);          // left border ignores heat
    send_cell('1, 18'd131072);
    send_cell('1, '0);
    send_cell('0, 18'd131072);
    send_cell('0, '0);
    send_cell(32'h0000_0001, 18'd1);
    send_cell(32'h8000_0000, 18'h10000);
    send_cell(32'h7FFF_FFFF, 18'h0FFFF);
    send_cell(32'h0001_0000, 18'd131072);
    send_cell(32'hFFFF_0000, 18'd1);
    send_cell(32'h0000_FFFF, 18'd131071);
    send_cell(32'hAAAA_AAAA, 18'h15555);
    send_cell(32'h5555_5555, 18'h0AAAA);
    send_cell(32'hFFFF_FFFE, 18'd131072);
    send_cell('1, '0);
    send_cell('0, 18'd131071);
    stream_cells(SIDE - 16);
    settle();

    // widest settings, then all zero with inverted limits
    program_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    stream_cells(SIDE / 4);
    settle();

    send_idle_pct = 63;
    recv_idle_pct = 20;
    program_regs(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    stream_cells(SIDE / 4);
    settle();

    program_regs(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
    stream_cells(SIDE / 4);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'($urandom_range(16'hFFFF, 16'hC000)), 16'($urandom_range(4000)),
                 16'($urandom_range(6000)), 16'($urandom_range(16'hFFFF)));
    stream_cells(SIDE / 4);
    settle();

    // back to back with a gentle decay and gain 256, i.e. new_value / 65536
    program_regs(16'd65500, 16'd0, 16'd40000, 16'd256);
    stream_cells(SIDE / 2);
    settle();

    $display("Streamed %0d cells under %0d register settings; %0d updated cells compared.",
             sent, settings_used, checked);
    $display("Covered borders, saturation, inverted limits and idle on either side.");
    if (outstanding != 0)
      $display("%0d expected updates never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("heat_diffusion_stencil_step verification clean");
    else
      $display("heat_diffusion_stencil_step verification failed");
    $finish;
  end

endmodule
